/* src/jpa_pkg.sv */
`default_nettype none

package jpa_pkg;

   localparam int unsigned NODE_W    = 10;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned MAX_NODES = 1024;

   localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ANCESTOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LCA      = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   typedef struct packed {
      logic              present;
      logic [NODE_W-1:0] parent;
      logic [NODE_W-1:0] depth;
      logic [NODE_W-1:0] jump;
   } rec_type;

   localparam int unsigned REC_W = $bits(rec_type);

   function automatic logic in_range(input logic [NODE_W-1:0] node);
      return 32'(node) < MAX_NODES;
   endfunction

endpackage

`default_nettype wire

/* src/jpa_if.sv */
`default_nettype none

interface jpa_req_if import jpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [NODE_W-1:0] main_node;
   logic [NODE_W-1:0] other_node;
   logic              has_parent;
   logic [NODE_W-1:0] steps;

   modport source (output valid, cmd, main_node, other_node, has_parent, steps,
                   input ready);
   modport sink   (input valid, cmd, main_node, other_node, has_parent, steps,
                   output ready);
endinterface

interface jpa_rsp_if import jpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NODE_W-1:0]   result_node;

   modport source (output valid, status, result_node, input ready);
   modport sink   (input valid, status, result_node, output ready);
endinterface

`default_nettype wire

/* src/jpa_ram.sv */
`default_nettype none

module jpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/jump_pointer_ancestor_lca.sv */
// steps: an add reads the node, then for a child the parent and two jump targets; k-th
// ancestor takes jumps and parent steps; lca lifts the deeper node, then walks both up
// throughput: one transaction in flight, the next one accepted in the cycle after the
// result is loaded; a stalled result holds the block in its done state
// reset: synchronous, then a clearing pass zeroes all 1024 entries of the node table,
// with req not ready until it ends
`default_nettype none

module jump_pointer_ancestor_lca import jpa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   jpa_req_if.sink   req_bus,
   jpa_rsp_if.source rsp_bus
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_ADD_J, S_ADD_JJ,
      S_CLIMB_J, S_CLIMB_P, S_LCA_CHK, S_LCA_RA, S_LCA_RB, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic                hp_ff, hp_in;
   logic [NODE_W-1:0]   k_ff, k_in;
   logic [NODE_W-1:0]   tgt_ff, tgt_in;
   logic                side_ff, side_in;
   rec_type             a_rec_ff, a_rec_in, b_rec_ff, b_rec_in, tmp_rec_ff, tmp_rec_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [NODE_W-1:0]   res_node_ff, res_node_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   rec_type           wr_rec;
   logic [NODE_W-1:0] rd_addr;
   rec_type           rd_rec;
   logic [REC_W-1:0]  rd_raw;

   jpa_ram #(.WIDTH(REC_W), .DEPTH(MAX_NODES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_rec = rec_type'(rd_raw);

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.result_node = rsp_node_ff;

   always_comb begin
      rec_type           cur_rec;
      logic              a_ok;
      logic              b_ok;
      logic              eq_span;
      logic              to_parent;

      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      hp_in         = hp_ff;
      k_in          = k_ff;
      tgt_in        = tgt_ff;
      side_in       = side_ff;
      a_rec_in      = a_rec_ff;
      b_rec_in      = b_rec_ff;
      tmp_rec_in    = tmp_rec_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      wr_en         = 1'b0;
      wr_addr       = a_ff;
      wr_rec        = '0;
      rd_addr       = a_ff;

      cur_rec   = side_ff ? b_rec_ff : a_rec_ff;
      a_ok      = in_range(a_ff) && rd_rec.present;
      b_ok      = in_range(b_ff) && rd_rec.present;
      eq_span   = (b_rec_ff.depth - tmp_rec_ff.depth) == (tmp_rec_ff.depth - rd_rec.depth);
      to_parent = (a_rec_ff.jump == b_rec_ff.jump);

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_rec  = '0;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_NODES - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = req_bus.main_node;
            if (req_bus.valid) begin
               cmd_in = req_bus.cmd;
               a_in   = req_bus.main_node;
               b_in   = req_bus.other_node;
               hp_in  = req_bus.has_parent;
               k_in   = req_bus.steps;
               if (req_bus.cmd == CMD_ADD || req_bus.cmd == CMD_ANCESTOR
                   || req_bus.cmd == CMD_LCA) begin
                  state_in = S_RD_A;
               end else begin
                  res_status_in = ST_BAD;
                  res_node_in   = '0;
                  state_in      = S_DONE;
               end
            end
         end
         S_RD_A: begin
            a_rec_in      = rd_rec;
            res_status_in = ST_BAD;
            res_node_in   = '0;
            rd_addr       = b_ff;
            case (cmd_ff)
               CMD_ADD: begin
                  if (!in_range(a_ff) || rd_rec.present) begin
                     state_in = S_DONE;
                  end else if (!hp_ff) begin
                     wr_en         = 1'b1;
                     wr_rec        = '{present: 1'b1, parent: a_ff, depth: '0, jump: a_ff};
                     res_status_in = ST_OK;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_RD_B;
                  end
               end
               CMD_ANCESTOR: begin
                  side_in = 1'b0;
                  tgt_in  = rd_rec.depth - k_ff;
                  rd_addr = rd_rec.jump;
                  if (!a_ok) begin
                     state_in = S_DONE;
                  end else if (k_ff > rd_rec.depth) begin
                     res_status_in = ST_NONE;
                     state_in      = S_DONE;
                  end else if (k_ff == '0) begin
                     res_status_in = ST_OK;
                     res_node_in   = a_ff;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_CLIMB_J;
                  end
               end
               default: begin
                  if (a_ok) begin
                     state_in = S_RD_B;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_RD_B: begin
            b_rec_in      = rd_rec;
            res_status_in = ST_BAD;
            res_node_in   = '0;
            if (!b_ok) begin
               state_in = S_DONE;
            end else if (cmd_ff == CMD_ADD) begin
               rd_addr  = rd_rec.jump;
               state_in = S_ADD_J;
            end else if (a_rec_ff.depth > rd_rec.depth) begin
               // lift a to the depth of b
               side_in  = 1'b0;
               tgt_in   = rd_rec.depth;
               rd_addr  = a_rec_ff.jump;
               state_in = S_CLIMB_J;
            end else if (a_rec_ff.depth == rd_rec.depth) begin
               state_in = S_LCA_CHK;
            end else begin
               side_in  = 1'b1;
               tgt_in   = a_rec_ff.depth;
               rd_addr  = rd_rec.jump;
               state_in = S_CLIMB_J;
            end
         end
         S_ADD_J: begin
            tmp_rec_in = rd_rec;
            rd_addr    = rd_rec.jump;
            state_in   = S_ADD_JJ;
         end
         S_ADD_JJ: begin
            wr_en         = 1'b1;
            wr_rec        = '{present: 1'b1, parent: b_ff,
                              depth: b_rec_ff.depth + 1'b1,
                              jump: eq_span ? tmp_rec_ff.jump : b_ff};
            res_status_in = ST_OK;
            res_node_in   = '0;
            state_in      = S_DONE;
         end
         S_CLIMB_J: begin
            // rd_rec holds the jump target of the climbing node
            if (rd_rec.depth > tgt_ff) begin
               if (side_ff) begin
                  b_in     = cur_rec.jump;
                  b_rec_in = rd_rec;
               end else begin
                  a_in     = cur_rec.jump;
                  a_rec_in = rd_rec;
               end
               rd_addr  = rd_rec.jump;
               state_in = S_CLIMB_J;
            end else begin
               rd_addr  = cur_rec.parent;
               state_in = S_CLIMB_P;
            end
         end
         S_CLIMB_P: begin
            if (side_ff) begin
               b_in     = cur_rec.parent;
               b_rec_in = rd_rec;
            end else begin
               a_in     = cur_rec.parent;
               a_rec_in = rd_rec;
            end
            rd_addr = rd_rec.jump;
            if (rd_rec.depth > tgt_ff) begin
               state_in = S_CLIMB_J;
            end else if (cmd_ff == CMD_ANCESTOR) begin
               res_status_in = ST_OK;
               res_node_in   = cur_rec.parent;
               state_in      = S_DONE;
            end else begin
               state_in = S_LCA_CHK;
            end
         end
         S_LCA_CHK: begin
            rd_addr = to_parent ? a_rec_ff.parent : a_rec_ff.jump;
            if (a_ff == b_ff) begin
               res_status_in = ST_OK;
               res_node_in   = a_ff;
               state_in      = S_DONE;
            end else if (a_rec_ff.depth == '0) begin
               // roots differ: nodes sit in different trees
               res_status_in = ST_NONE;
               res_node_in   = '0;
               state_in      = S_DONE;
            end else begin
               a_in     = rd_addr;
               b_in     = to_parent ? b_rec_ff.parent : b_rec_ff.jump;
               state_in = S_LCA_RA;
            end
         end
         S_LCA_RA: begin
            a_rec_in = rd_rec;
            rd_addr  = b_ff;
            state_in = S_LCA_RB;
         end
         S_LCA_RB: begin
            b_rec_in = rd_rec;
            state_in = S_LCA_CHK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_node_in   = res_node_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      hp_ff         <= hp_in;
      k_ff          <= k_in;
      tgt_ff        <= tgt_in;
      side_ff       <= side_in;
      a_rec_ff      <= a_rec_in;
      b_rec_ff      <= b_rec_in;
      tmp_rec_ff    <= tmp_rec_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
   end

`ifndef SYNTHESIS
   a_write_only_add: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != S_CLEAR |-> cmd_ff == CMD_ADD)
      else $error("node table written outside an add");

   a_fail_zero_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_node_ff == '0)
      else $error("failed response carries a node");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("second transaction taken while busy");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");
`endif

endmodule

`default_nettype wire

/* tb/jpa_lca_checker.sv */
`default_nettype none

module jpa_lca_checker import jpa_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   jpa_req_if          req_mon,
   jpa_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   node;
   } answer_type;

   logic [NODE_W-1:0] up_of    [MAX_NODES];
   logic [NODE_W-1:0] level_of [MAX_NODES];
   logic [NODE_W-1:0] skip_of  [MAX_NODES];
   bit                in_forest[MAX_NODES];

   answer_type  answers_due[$];
   int unsigned mismatches = 0;

   // jumps are only taken when they stay strictly above the target depth
   function automatic logic [NODE_W-1:0] climb_by(input logic [NODE_W-1:0] node,
                                                  input logic [NODE_W-1:0] k);
      logic [NODE_W-1:0] target;
      logic [NODE_W-1:0] hop;
      target = level_of[node] - k;
      while (level_of[node] > target) begin
         hop = skip_of[node];
         if (level_of[hop] <= target)
            node = up_of[node];
         else
            node = hop;
      end
      return node;
   endfunction

   function automatic answer_type answer_of(input logic [CMD_W-1:0]  cmd,
                                            input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b,
                                            input logic              hp,
                                            input logic [NODE_W-1:0] k);
      answer_type        ans;
      logic [NODE_W-1:0] j1;
      logic [NODE_W-1:0] j2;
      ans.status = ST_BAD;
      ans.node   = '0;
      case (cmd)
         CMD_ADD: begin
            if (!in_forest[a] && (!hp || in_forest[b])) begin
               if (!hp) begin
                  up_of[a]    = a;
                  level_of[a] = '0;
                  skip_of[a]  = a;
               end else begin
                  j1          = skip_of[b];
                  j2          = skip_of[j1];
                  up_of[a]    = b;
                  level_of[a] = level_of[b] + 1'b1;
                  // equal spans merge into one jump twice as long
                  if (level_of[b] - level_of[j1] == level_of[j1] - level_of[j2])
                     skip_of[a] = j2;
                  else
                     skip_of[a] = b;
               end
               in_forest[a] = 1'b1;
               ans.status   = ST_OK;
            end
         end
         CMD_ANCESTOR: begin
            if (in_forest[a]) begin
               if (k > level_of[a]) begin
                  ans.status = ST_NONE;
               end else begin
                  ans.node   = climb_by(a, k);
                  ans.status = ST_OK;
               end
            end
         end
         CMD_LCA: begin
            if (in_forest[a] && in_forest[b]) begin
               if (level_of[a] > level_of[b])
                  a = climb_by(a, level_of[a] - level_of[b]);
               else
                  b = climb_by(b, level_of[b] - level_of[a]);
               ans.status = ST_OK;
               while (a != b && ans.status == ST_OK) begin
                  // both at a root and still apart: different trees
                  if (level_of[a] == '0) begin
                     ans.status = ST_NONE;
                  end else if (skip_of[a] == skip_of[b]) begin
                     a = up_of[a];
                     b = up_of[b];
                  end else begin
                     a = skip_of[a];
                     b = skip_of[b];
                  end
               end
               if (ans.status == ST_OK)
                  ans.node = a;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         foreach (in_forest[i])
            in_forest[i] = 1'b0;
         answers_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            answers_due.push_back(answer_of(req_mon.cmd, req_mon.main_node,
                                            req_mon.other_node, req_mon.has_parent,
                                            req_mon.steps));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answers_due.size() == 0) begin
               $error("result with no transaction outstanding: status %0d, result_node %0d",
                      rsp_mon.status, rsp_mon.result_node);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_mon.status !== due.status || rsp_mon.result_node !== due.node)
                  mismatches++;
               if (rsp_mon.status !== due.status)
                  $error("status: expected %0d, got %0d", due.status, rsp_mon.status);
               if (rsp_mon.result_node !== due.node)
                  $error("result_node: expected %0d, got %0d", due.node,
                         rsp_mon.result_node);
            end
         end
      end
      fail_count <= mismatches;
      pending    <= answers_due.size();
   end

endmodule

`default_nettype wire

/* tb/tb_jump_pointer_ancestor_lca.sv */
`default_nettype none

module tb_jump_pointer_ancestor_lca import jpa_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
   localparam int unsigned      RANDOM_ITEMS = 1030;

   logic clock = 1'b0;
   logic reset;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   jpa_req_if req_bus();
   jpa_rsp_if rsp_bus();

   int unsigned fails;
   int unsigned pending;

   jump_pointer_ancestor_lca dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   jpa_lca_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fails),
      .pending    (pending)
   );

   // forest as seen by the stimulus, used to aim queries at real nodes, adds at free ones, and for the summary
   bit                have[MAX_NODES];
   int unsigned       depth_seen[MAX_NODES];
   logic [NODE_W-1:0] members[$];
   logic [NODE_W-1:0] newest;
   int unsigned       deepest = 0;
   int unsigned       n_sent[4] = '{default: 0};

   bit          calm = 1'b0;
   int unsigned stall_left = 0;

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [NODE_W-1:0] pick_member();
      return members[$urandom_range(0, members.size() - 1)];
   endfunction

   function automatic logic [NODE_W-1:0] pick_free();
      logic [NODE_W-1:0] n;
      n = NODE_W'($urandom_range(0, MAX_NODES - 1));
      if (members.size() < MAX_NODES)
         while (have[n])
            n = NODE_W'($urandom_range(0, MAX_NODES - 1));
      return n;
   endfunction

   task automatic send(input logic [CMD_W-1:0]  cmd,
                       input logic [NODE_W-1:0] a,
                       input logic [NODE_W-1:0] b,
                       input logic              hp,
                       input logic [NODE_W-1:0] k);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.main_node  <= a;
      req_bus.other_node <= b;
      req_bus.has_parent <= hp;
      req_bus.steps      <= k;
      do @(posedge clock); while (!req_bus.ready);
      if (cmd == CMD_ADD && !have[a] && (!hp || have[b])) begin
         have[a]       = 1'b1;
         depth_seen[a] = hp ? depth_seen[b] + 1 : 0;
         if (depth_seen[a] > deepest)
            deepest = depth_seen[a];
         members.push_back(a);
         newest = a;
      end
      n_sent[cmd]++;
      @(negedge clock);
   endtask

   task automatic random_item();
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic [NODE_W-1:0] k;
      int unsigned       r;
      int unsigned       pick;
      r = $urandom_range(0, 99);
      a = NODE_W'($urandom_range(0, MAX_NODES - 1));
      b = NODE_W'($urandom_range(0, MAX_NODES - 1));
      k = NODE_W'($urandom_range(0, MAX_NODES - 1));
      if (members.size() == 0 || r < 38) begin
         a = pick_free();
         if (members.size() == 0 || $urandom_range(0, 99) < 8) begin
            send(CMD_ADD, a, b, 1'b0, k);
         end else begin
            // mostly extend the latest node so chains grow deep
            b = ($urandom_range(0, 99) < 70) ? newest : pick_member();
            send(CMD_ADD, a, b, 1'b1, k);
         end
      end else if (r < 68) begin
         a    = pick_member();
         pick = $urandom_range(0, 99);
         if (pick < 80)
            k = NODE_W'($urandom_range(0, depth_seen[a]));
         else if (pick < 90 && depth_seen[a] < MAX_NODES - 1)
            k = NODE_W'(depth_seen[a] + 1);
         send(CMD_ANCESTOR, a, b, 1'($urandom_range(0, 1)), k);
      end else if (r < 95) begin
         a = pick_member();
         b = ($urandom_range(0, 99) < 15) ? a : pick_member();
         send(CMD_LCA, a, b, 1'($urandom_range(0, 1)), k);
      end else begin
         send(CMD_W'($urandom_range(0, 3)), a, b, 1'($urandom_range(0, 1)), k);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30)
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $display("tb_jump_pointer_ancestor_lca NOT OK");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_ADD;
      req_bus.main_node  = '0;
      req_bus.other_node = '0;
      req_bus.has_parent = 1'b0;
      req_bus.steps      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(CMD_ADD,      10'd0,    10'd1023, 1'b0, 10'd1023);
      send(CMD_ADD,      10'd1023, 10'd0,    1'b1, 10'd0);
      send(CMD_ADD,      10'd0,    10'd0,    1'b0, 10'd0);
      send(CMD_ADD,      10'd5,    10'd7,    1'b1, 10'd0);
      send(CMD_ANCESTOR, 10'd1023, 10'd0,    1'b0, 10'd0);
      send(CMD_ANCESTOR, 10'd1023, 10'd0,    1'b1, 10'd1);
      send(CMD_ANCESTOR, 10'd1023, 10'd0,    1'b0, 10'd2);
      send(CMD_ANCESTOR, 10'd1023, 10'd1023, 1'b1, 10'd1023);
      send(CMD_ANCESTOR, 10'd7,    10'd0,    1'b0, 10'd0);
      send(CMD_LCA,      10'd0,    10'd1023, 1'b0, 10'd0);
      send(CMD_LCA,      10'd1023, 10'd1023, 1'b0, 10'd0);
      send(CMD_ADD,      10'd512,  10'd0,    1'b0, 10'd0);
      send(CMD_LCA,      10'd1023, 10'd512,  1'b0, 10'd0);
      send(CMD_LCA,      10'd512,  10'd7,    1'b0, 10'd0);
      send(CMD_UNUSED,   10'd0,    10'd0,    1'b0, 10'd0);
      send(CMD_UNUSED,   10'd1023, 10'd1023, 1'b1, 10'd1023);
      // short chain under 1023 so the jump pointers skip levels
      send(CMD_ADD,      10'd1,    10'd1023, 1'b1, 10'd0);
      send(CMD_ADD,      10'd2,    10'd1,    1'b1, 10'd0);
      send(CMD_ADD,      10'd3,    10'd2,    1'b1, 10'd0);
      send(CMD_ADD,      10'd4,    10'd3,    1'b1, 10'd0);
      send(CMD_ANCESTOR, 10'd4,    10'd0,    1'b0, 10'd3);
      send(CMD_LCA,      10'd4,    10'd1023, 1'b0, 10'd0);
      send(CMD_LCA,      10'd2,    10'd4,    1'b1, 10'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i % 200) >= 170;
         random_item();
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d adds, %0d ancestor queries, %0d lca queries, %0d unknown commands",
               n_sent[CMD_ADD], n_sent[CMD_ANCESTOR], n_sent[CMD_LCA], n_sent[CMD_UNUSED]);
      $display("forest grew to %0d nodes, deepest node at depth %0d", members.size(), deepest);
      if (fails == 0)
         $display("tb_jump_pointer_ancestor_lca OK");
      else
         $display("tb_jump_pointer_ancestor_lca NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
